### rtl/rlkne_pkg.sv
// Shared types and constants of the radius-limited k-nearest edge finder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package rlkne_pkg;

	// Fixed field widths of the input, output and configuration beats.
	localparam int SLOT_W   = 10;
	localparam int ID_W     = 16;
	localparam int POS_W    = 24;
	localparam int RADIUS_W = 24;
	localparam int LIMIT_W  = 5;
	localparam int ACTIVE_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int RSQ_W    = 2 * RADIUS_W;

	// Command codes of an input beat.
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONNECT_RADIUS = 2'd0,
		REG_NEIGHBOR_LIMIT = 2'd1,
		REG_ACTIVE_NODES   = 2'd2
	} reg_idx_t;

	// Configuration as seen by the search engine.
	typedef struct packed {
		logic [RADIUS_W-1:0] connect_radius;
		logic [LIMIT_W-1:0]  neighbor_limit;
		logic [ACTIVE_W-1:0] active_nodes;
	} cfg_t;

	// Query queue status toward the front end.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

### rtl/rlkne_if.sv
// Valid/ready channel interfaces for input items and result edges.
// Depends on rlkne_pkg for the field widths.
interface rlkne_in_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [rlkne_pkg::SLOT_W-1:0] slot_index;
	logic [rlkne_pkg::ID_W-1:0]   node_id;
	logic signed [rlkne_pkg::POS_W-1:0] pos_x;
	logic signed [rlkne_pkg::POS_W-1:0] pos_y;

	modport source (output valid, command, slot_index, node_id, pos_x, pos_y, input ready);
	modport sink (input valid, command, slot_index, node_id, pos_x, pos_y, output ready);
endinterface

interface rlkne_out_if;
	logic                       valid;
	logic                       ready;
	logic [rlkne_pkg::ID_W-1:0] source_node_id;
	logic [rlkne_pkg::ID_W-1:0] target_node_id;
	logic                       edge_valid;
	logic                       last_edge;

	modport source (output valid, source_node_id, target_node_id, edge_valid, last_edge,
		input ready);
	modport sink (input valid, source_node_id, target_node_id, edge_valid, last_edge,
		output ready);
endinterface

### rtl/rlkne_front.sv
// Front end: accepts input beats, turns loads into node store writes and queues queries.
// Depends on rlkne_pkg and rlkne_in_if.
module rlkne_front #(
	parameter int MAX_NODES  = 1024,
	parameter int COORD_BITS = 24,
	parameter int AW         = 10,
	parameter int ENTRY_W    = 64
) (
	rlkne_in_if.sink                 in_ch,
	input  rlkne_pkg::queue_stat_t   q_stat,
	input  logic                     back_idle,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic [ENTRY_W-1:0]       mem_wdata,
	output logic                     q_push,
	output logic [rlkne_pkg::SLOT_W-1:0] q_slot
);

	logic is_load;
	logic slot_ok;
	logic accept;

	// A load waits until every earlier query has finished reading the store.
	assign is_load = (in_ch.command == rlkne_pkg::CMD_LOAD);
	assign in_ch.ready = is_load ? (q_stat.empty && back_idle) : !q_stat.full;
	assign accept = in_ch.valid && in_ch.ready;

	// Loads to slots beyond the store are dropped.
	assign slot_ok = (32'(in_ch.slot_index) < MAX_NODES);
	assign mem_we = accept && is_load && slot_ok;
	assign mem_waddr = AW'(in_ch.slot_index);
	assign mem_wdata = {in_ch.node_id, COORD_BITS'(in_ch.pos_x), COORD_BITS'(in_ch.pos_y)};

	// Queries go to the queue with their raw slot index.
	assign q_push = accept && !is_load;
	assign q_slot = in_ch.slot_index;

endmodule

### rtl/rlkne_queue.sv
// Two-entry query queue between the front end and the search engine.
// Depends on rlkne_pkg.
module rlkne_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [rlkne_pkg::SLOT_W-1:0]  push_slot,
	input  logic                          pop,
	output logic [rlkne_pkg::SLOT_W-1:0]  head_slot,
	output rlkne_pkg::queue_stat_t        stat
);

	logic [rlkne_pkg::SLOT_W-1:0] slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign head_slot  = slot_q[rd_ptr_q];
	assign stat.full  = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_slot;
	end

endmodule

### rtl/rlkne_back.sv
// Search engine: node store, streaming distance pipeline, sorted best list and edge output.
// Depends on rlkne_pkg and rlkne_out_if.
module rlkne_back #(
	parameter int MAX_NODES     = 1024,
	parameter int MAX_NEIGHBORS = 16,
	parameter int COORD_BITS    = 24,
	parameter int AW            = 10,
	parameter int ENTRY_W       = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlkne_pkg::cfg_t               cfg,
	input  logic                          mem_we,
	input  logic [AW-1:0]                 mem_waddr,
	input  logic [ENTRY_W-1:0]            mem_wdata,
	input  logic                          q_valid,
	input  logic [rlkne_pkg::SLOT_W-1:0]  q_slot,
	output logic                          q_pop,
	output logic                          idle,
	rlkne_out_if.source                   out_ch
);

	localparam int C    = COORD_BITS;
	localparam int DW   = 2 * C + 2;
	localparam int CMPW = (DW > rlkne_pkg::RSQ_W) ? DW : rlkne_pkg::RSQ_W;
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
	localparam int KI   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int IW   = rlkne_pkg::ID_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SRC_RD, S_SRC_CAP, S_WALK, S_EMIT_RD, S_EMIT_WR, S_NONE
	} state_t;

	state_t state_q;

	// Node store, one entry per slot: {id, x, y}.
	logic [ENTRY_W-1:0] mem [MAX_NODES];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [AW-1:0]      rd_addr;

	// Query context.
	logic                  src_ok_q;
	logic [AW-1:0]         src_addr_q;
	logic [IW-1:0]         src_id_q;
	logic [C-1:0]          sx_q;
	logic [C-1:0]          sy_q;
	logic [CW-1:0]         t_q;
	logic [CW-1:0]         count_q;
	logic [KW-1:0]         limit_q;
	logic [rlkne_pkg::RSQ_W-1:0] rsq_q;

	// Distance pipeline.
	logic                  issue;
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0]         slot_s1, slot_s2, slot_s3, slot_s4;
	logic [C:0]            ux_s2, uy_s2;
	logic [DW-1:0]         sqx_s3, sqy_s3;
	logic [DW-1:0]         d_s4;
	logic signed [C:0]     dx, dy;
	logic [C-1:0]          rx, ry;

	// Best list.
	logic [DW-1:0]         best_d_q [MAX_NEIGHBORS];
	logic [AW-1:0]         best_slot_q [MAX_NEIGHBORS];
	logic [KW-1:0]         cnt_q;
	logic [KI-1:0]         k_q;
	logic                  gt [MAX_NEIGHBORS];
	logic                  ins_any;
	logic                  ins_en;
	logic                  pipe_empty;
	logic                  out_free;
	logic                  out_load;
	logic                  emit_last;

	// Output register.
	logic                  out_v_q;
	logic [IW-1:0]         out_src_q;
	logic [IW-1:0]         out_tgt_q;
	logic                  out_edge_q;
	logic                  out_last_q;

	assign idle  = (state_q == S_IDLE);
	assign q_pop = idle && q_valid;
	assign issue = (state_q == S_WALK) && src_ok_q && (t_q < count_q);
	assign pipe_empty = !issue && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign out_free = !out_v_q || out_ch.ready;
	assign out_load = out_free && ((state_q == S_EMIT_WR) || (state_q == S_NONE));
	assign emit_last = ((KW'(k_q) + KW'(1)) == cnt_q);

	assign out_ch.valid          = out_v_q;
	assign out_ch.source_node_id = out_src_q;
	assign out_ch.target_node_id = out_tgt_q;
	assign out_ch.edge_valid     = out_edge_q;
	assign out_ch.last_edge      = out_last_q;

	// Read address of the single store read port.
	always_comb begin
		case (state_q)
			S_WALK:               rd_addr = t_q[AW-1:0];
			S_EMIT_RD, S_EMIT_WR: rd_addr = best_slot_q[k_q];
			default:              rd_addr = src_addr_q;
		endcase
	end

	// Store write from the front end and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[rd_addr];
	end

	// Coordinate differences against the source node.
	assign rx = rd_data_q[2*C-1:C];
	assign ry = rd_data_q[C-1:0];
	assign dx = $signed({rx[C-1], rx}) - $signed({sx_q[C-1], sx_q});
	assign dy = $signed({ry[C-1], ry}) - $signed({sy_q[C-1], sy_q});

	// Insertion point: the first entry strictly farther than the new distance.
	always_comb begin
		ins_any = 1'b0;
		for (int i = 0; i < MAX_NEIGHBORS; i++) begin
			gt[i] = (best_d_q[i] > d_s4) && (KW'(i) < limit_q);
			ins_any = ins_any | gt[i];
		end
	end
	assign ins_en = v_s4 && (CMPW'(d_s4) <= CMPW'(rsq_q)) && ins_any;

	// Distance pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= t_q[AW-1:0];
		slot_s2 <= slot_s1;
		slot_s3 <= slot_s2;
		slot_s4 <= slot_s3;
		ux_s2   <= dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
		uy_s2   <= dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
		sqx_s3  <= DW'(ux_s2) * DW'(ux_s2);
		sqy_s3  <= DW'(uy_s2) * DW'(uy_s2);
		d_s4    <= sqx_s3 + sqy_s3;
	end

	// Sequencer, best list and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			src_ok_q   <= 1'b0;
			src_addr_q <= '0;
			src_id_q   <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			t_q        <= '0;
			count_q    <= '0;
			limit_q    <= '0;
			rsq_q      <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			out_v_q    <= 1'b0;
			out_src_q  <= '0;
			out_tgt_q  <= '0;
			out_edge_q <= 1'b0;
			out_last_q <= 1'b0;
			for (int i = 0; i < MAX_NEIGHBORS; i++) begin
				best_d_q[i]    <= '1;
				best_slot_q[i] <= '0;
			end
		end else begin
			if (out_ch.ready && !out_load) out_v_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						src_ok_q   <= (32'(q_slot) < MAX_NODES);
						src_addr_q <= AW'(q_slot);
						t_q        <= (32'(q_slot) < MAX_NODES) ? CW'(q_slot) + CW'(1) : '0;
						count_q    <= (32'(cfg.active_nodes) > MAX_NODES) ?
							CW'(MAX_NODES) : CW'(cfg.active_nodes);
						limit_q    <= (32'(cfg.neighbor_limit) > MAX_NEIGHBORS) ?
							KW'(MAX_NEIGHBORS) : KW'(cfg.neighbor_limit);
						rsq_q      <= rlkne_pkg::RSQ_W'(cfg.connect_radius) *
							rlkne_pkg::RSQ_W'(cfg.connect_radius);
						cnt_q      <= '0;
						k_q        <= '0;
						for (int i = 0; i < MAX_NEIGHBORS; i++) begin
							best_d_q[i]    <= '1;
							best_slot_q[i] <= '0;
						end
						state_q <= S_SRC_RD;
					end
				end
				S_SRC_RD: begin
					state_q <= S_SRC_CAP;
				end
				S_SRC_CAP: begin
					src_id_q <= src_ok_q ? rd_data_q[ENTRY_W-1 -: IW] : '0;
					sx_q     <= rd_data_q[2*C-1:C];
					sy_q     <= rd_data_q[C-1:0];
					state_q  <= S_WALK;
				end
				S_WALK: begin
					if (issue) t_q <= t_q + CW'(1);
					// Shift farther entries down one place and drop the new one in.
					if (ins_en) begin
						for (int i = 0; i < MAX_NEIGHBORS; i++) begin
							if (gt[i]) begin
								if (i == 0 || !gt[(i == 0) ? 0 : i - 1]) begin
									best_d_q[i]    <= d_s4;
									best_slot_q[i] <= slot_s4;
								end else begin
									best_d_q[i]    <= best_d_q[(i == 0) ? 0 : i - 1];
									best_slot_q[i] <= best_slot_q[(i == 0) ? 0 : i - 1];
								end
							end
						end
						if (cnt_q < limit_q) cnt_q <= cnt_q + KW'(1);
					end
					if (pipe_empty) state_q <= (cnt_q == '0) ? S_NONE : S_EMIT_RD;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_src_q  <= src_id_q;
						out_tgt_q  <= rd_data_q[ENTRY_W-1 -: IW];
						out_edge_q <= 1'b1;
						out_last_q <= emit_last;
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KI'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_NONE: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_src_q  <= src_id_q;
						out_tgt_q  <= '0;
						out_edge_q <= 1'b0;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The list never holds more entries than the clamped limit.
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= limit_q) else $error("best list count exceeds limit");

	// The two nearest kept entries stay in ascending order.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(MAX_NEIGHBORS > 1 && cnt_q >= KW'(2)) |->
		(best_d_q[0] <= best_d_q[(MAX_NEIGHBORS > 1) ? 1 : 0]))
		else $error("best list out of order");

	// Distances only arrive while the store is being walked.
	a_walk_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (state_q == S_WALK)) else $error("distance outside walk");

	// Every popped query starts a search by moving to S_SRC_RD.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_SRC_RD)) else $error("query pop without start");
`endif

endmodule

### rtl/radius_limited_k_nearest_edges.sv
// Radius-limited k-nearest edge finder: a query walks the slots above its source through the
// single node store read port at one distance a cycle, then reads the id of each kept target
// from the store before emitting its edge.
// Throughput: loads one per cycle when no query is pending; queries one at a time.
// Reset (arst_n low, asynchronous) clears control, the best list and the registers to
// their defaults; the node store has no reset and holds undefined data until loaded.
module radius_limited_k_nearest_edges #(
	parameter int MAX_NODES     = 1024,
	parameter int MAX_NEIGHBORS = 16,
	parameter int COORD_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rlkne_in_if.sink                          in_ch,
	rlkne_out_if.source                       out_ch,
	input  logic                              cfg_we,
	input  logic [rlkne_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlkne_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int ENTRY_W = rlkne_pkg::ID_W + 2 * COORD_BITS;

	rlkne_pkg::cfg_t        cfg_q;
	rlkne_pkg::queue_stat_t q_stat;
	logic                   back_idle;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [ENTRY_W-1:0]     mem_wdata;
	logic                   q_push;
	logic                   q_pop;
	logic [rlkne_pkg::SLOT_W-1:0] push_slot;
	logic [rlkne_pkg::SLOT_W-1:0] head_slot;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_radius <= rlkne_pkg::RADIUS_W'(25600);
			cfg_q.neighbor_limit <= rlkne_pkg::LIMIT_W'(4);
			cfg_q.active_nodes   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rlkne_pkg::REG_CONNECT_RADIUS:
					cfg_q.connect_radius <= cfg_data[rlkne_pkg::RADIUS_W-1:0];
				rlkne_pkg::REG_NEIGHBOR_LIMIT:
					cfg_q.neighbor_limit <= cfg_data[rlkne_pkg::LIMIT_W-1:0];
				rlkne_pkg::REG_ACTIVE_NODES:
					cfg_q.active_nodes <= cfg_data[rlkne_pkg::ACTIVE_W-1:0];
				default: ;
			endcase
		end
	end

	rlkne_front #(
		.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS), .AW(AW), .ENTRY_W(ENTRY_W)
	) u_front (
		.in_ch(in_ch), .q_stat(q_stat), .back_idle(back_idle),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.q_push(q_push), .q_slot(push_slot)
	);

	rlkne_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_slot(push_slot),
		.pop(q_pop), .head_slot(head_slot), .stat(q_stat)
	);

	rlkne_back #(
		.MAX_NODES(MAX_NODES), .MAX_NEIGHBORS(MAX_NEIGHBORS), .COORD_BITS(COORD_BITS),
		.AW(AW), .ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.q_valid(!q_stat.empty), .q_slot(head_slot), .q_pop(q_pop),
		.idle(back_idle), .out_ch(out_ch)
	);

endmodule

### test/radius_limited_k_nearest_edges_checker.sv
// Watches the item and edge channels of the k-nearest edge finder, predicts each query's edges
// and compares them beat by beat. Depends on rlkne_pkg and the channel interfaces in rlkne_if.
module radius_limited_k_nearest_edges_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	rlkne_in_if                              in_ch,
	rlkne_out_if                             out_ch,
	input  logic                             cfg_we,
	input  logic [rlkne_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rlkne_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                               failures,
	output int                               edges_pending
);

	localparam int NODES = 1024;
	localparam int NEIGHBORS = 16;

	typedef struct {
		logic [rlkne_pkg::ID_W-1:0] source_id;
		logic [rlkne_pkg::ID_W-1:0] target_id;
		logic                       edge_valid;
		logic                       last_edge;
	} edge_t;

	// Mirror of the node store and of the configuration registers.
	logic signed [rlkne_pkg::POS_W-1:0] node_x [NODES];
	logic signed [rlkne_pkg::POS_W-1:0] node_y [NODES];
	logic [rlkne_pkg::ID_W-1:0]         node_id [NODES];
	logic [rlkne_pkg::RADIUS_W-1:0]     radius;
	logic [rlkne_pkg::LIMIT_W-1:0]      limit_reg;
	logic [rlkne_pkg::ACTIVE_W-1:0]     active_reg;
	edge_t                              edge_q [$];

	task automatic report(input string what, input longint want, input longint got);
		$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
		failures++;
	endtask

	// Walks the slots above the source and queues the nearest edges within the radius.
	function automatic void predict_edges(input logic [rlkne_pkg::SLOT_W-1:0] src);
		logic [49:0] near_dist [NEIGHBORS];
		int          near_slot [NEIGHBORS];
		int          kept;
		int          lim;
		int          cnt;
		int          pos;
		logic [49:0] rsq;
		logic [49:0] d;
		longint      dx;
		longint      dy;
		edge_t       e;
		kept = 0;
		lim = (limit_reg > NEIGHBORS) ? NEIGHBORS : int'(limit_reg);
		cnt = (active_reg > NODES) ? NODES : int'(active_reg);
		rsq = 50'(radius) * 50'(radius);
		for (int t = int'(src) + 1; t < cnt; t++) begin
			dx = longint'(node_x[src]) - longint'(node_x[t]);
			dy = longint'(node_y[src]) - longint'(node_y[t]);
			d = 50'(dx * dx + dy * dy);
			if (d <= rsq) begin
				// An equal distance lands after the ones already kept.
				pos = kept;
				while (pos > 0 && near_dist[pos-1] > d)
					pos--;
				if (pos < lim) begin
					if (kept < lim)
						kept++;
					for (int i = kept - 1; i > pos; i--) begin
						near_dist[i] = near_dist[i-1];
						near_slot[i] = near_slot[i-1];
					end
					near_dist[pos] = d;
					near_slot[pos] = t;
				end
			end
		end
		e.source_id = node_id[src];
		if (kept == 0) begin
			e.target_id = '0;
			e.edge_valid = 1'b0;
			e.last_edge = 1'b1;
			edge_q.push_back(e);
		end
		for (int k = 0; k < kept; k++) begin
			e.target_id = node_id[near_slot[k]];
			e.edge_valid = 1'b1;
			e.last_edge = (k == kept - 1);
			edge_q.push_back(e);
		end
	endfunction

	// Track register writes, accepted items and accepted edges.
	always @(posedge clk or negedge arst_n) begin
		edge_t want;
		if (!arst_n) begin
			radius <= 24'd25600;
			limit_reg <= 5'd4;
			active_reg <= '0;
			failures <= 0;
			edges_pending <= 0;
			edge_q.delete();
		end else begin
			if (cfg_we) begin
				case (rlkne_pkg::reg_idx_t'(cfg_index))
					rlkne_pkg::REG_CONNECT_RADIUS:
						radius <= cfg_data[rlkne_pkg::RADIUS_W-1:0];
					rlkne_pkg::REG_NEIGHBOR_LIMIT:
						limit_reg <= cfg_data[rlkne_pkg::LIMIT_W-1:0];
					rlkne_pkg::REG_ACTIVE_NODES:
						active_reg <= cfg_data[rlkne_pkg::ACTIVE_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				if (rlkne_pkg::cmd_t'(in_ch.command) == rlkne_pkg::CMD_LOAD) begin
					node_id[in_ch.slot_index] = in_ch.node_id;
					node_x[in_ch.slot_index] = in_ch.pos_x;
					node_y[in_ch.slot_index] = in_ch.pos_y;
				end else begin
					predict_edges(in_ch.slot_index);
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (edge_q.size() == 0) begin
					report("edge beat with nothing expected", 0, 1);
				end else begin
					want = edge_q.pop_front();
					if (out_ch.source_node_id !== want.source_id)
						report("source_node_id", want.source_id, out_ch.source_node_id);
					if (out_ch.target_node_id !== want.target_id)
						report("target_node_id", want.target_id, out_ch.target_node_id);
					if (out_ch.edge_valid !== want.edge_valid)
						report("edge_valid", want.edge_valid, out_ch.edge_valid);
					if (out_ch.last_edge !== want.last_edge)
						report("last_edge", want.last_edge, out_ch.last_edge);
				end
			end
			edges_pending <= edge_q.size();
		end
	end
endmodule

### test/radius_limited_k_nearest_edges_test.sv
// Stimulus and verdict for the k-nearest edge finder: loads nodes, sweeps register settings
// and queries under random stalls. Depends on rlkne_pkg, rlkne_if and the checker module.
module radius_limited_k_nearest_edges_test;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		rlkne_pkg::cmd_t                    command;
		logic [rlkne_pkg::SLOT_W-1:0]       slot;
		logic [rlkne_pkg::ID_W-1:0]         id;
		logic signed [rlkne_pkg::POS_W-1:0] x;
		logic signed [rlkne_pkg::POS_W-1:0] y;
	} item_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [rlkne_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rlkne_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int                               failures;
	int                               edges_pending;
	int                               send_idle = 0;
	int                               recv_idle = 0;
	int                               hold_left = 0;
	int                               cycles = 0;
	item_t                            item_q [$];

	rlkne_in_if  in_ch ();
	rlkne_out_if out_ch ();

	radius_limited_k_nearest_edges u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	radius_limited_k_nearest_edges_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .edges_pending(edges_pending)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = 1'b0;
		in_ch.slot_index = '0;
		in_ch.node_id = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		out_ch.ready = 1'b0;
	end

	// Item driver: keeps a beat steady until taken, otherwise offers the next one or idles.
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			void'(item_q.pop_front());
		if (in_ch.valid && !in_ch.ready) begin
		end else if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
			in_ch.valid <= 1'b1;
			in_ch.command <= item_q[0].command;
			in_ch.slot_index <= item_q[0].slot;
			in_ch.node_id <= item_q[0].id;
			in_ch.pos_x <= item_q[0].x;
			in_ch.pos_y <= item_q[0].y;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Edge receiver, held off entirely while a long stall is running.
	always @(posedge clk)
		out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);

	always @(posedge clk)
		if (hold_left > 0)
			hold_left <= hold_left - 1;

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic load(input int slot, input int id, input int x, input int y);
		item_t it;
		it.command = rlkne_pkg::CMD_LOAD;
		it.slot = slot[rlkne_pkg::SLOT_W-1:0];
		it.id = id[rlkne_pkg::ID_W-1:0];
		it.x = x[rlkne_pkg::POS_W-1:0];
		it.y = y[rlkne_pkg::POS_W-1:0];
		item_q.push_back(it);
	endtask

	task automatic query(input int slot);
		item_t it;
		it.command = rlkne_pkg::CMD_QUERY;
		it.slot = slot[rlkne_pkg::SLOT_W-1:0];
		it.id = rlkne_pkg::ID_W'($urandom);
		it.x = rlkne_pkg::POS_W'($urandom);
		it.y = rlkne_pkg::POS_W'($urandom);
		item_q.push_back(it);
	endtask

	// Waits until every item is taken and every edge has arrived, plus a short drain.
	task automatic settle();
		while (item_q.size() > 0 || in_ch.valid)
			@(posedge clk);
		@(posedge clk);
		while (edges_pending > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input rlkne_pkg::reg_idx_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[rlkne_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Only slots 0..63 and 960..1023 are ever loaded, so queries stay on written slots.
	function automatic int loaded_slot();
		return $urandom_range(1) ? $urandom_range(63) : $urandom_range(1023, 960);
	endfunction

	function automatic int cluster_coord();
		return int'($urandom_range(10240)) - 5120;
	endfunction

	function automatic int wide_coord();
		return int'($urandom_range(16777215)) - 8388608;
	endfunction

	task automatic random_load();
		if ($urandom_range(3) == 0)
			load(loaded_slot(), $urandom, wide_coord(), wide_coord());
		else
			load(loaded_slot(), $urandom, cluster_coord(), cluster_coord());
	endtask

	// Random register setting; a large active count keeps sources in the upper block.
	task automatic random_setting(output int wide_active);
		int r;
		r = $urandom_range(9);
		write_reg(rlkne_pkg::REG_CONNECT_RADIUS,
			r == 0 ? 0 : r == 1 ? 16777215 : $urandom_range(12000));
		write_reg(rlkne_pkg::REG_NEIGHBOR_LIMIT,
			$urandom_range(9) == 0 ? $urandom_range(31, 16) : $urandom_range(16));
		wide_active = $urandom_range(1);
		write_reg(rlkne_pkg::REG_ACTIVE_NODES,
			wide_active ? $urandom_range(2047, 960) : $urandom_range(64));
	endtask

	task automatic random_block(input int items);
		int wide_active;
		random_setting(wide_active);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 30)
				random_load();
			else
				query(wide_active ? $urandom_range(1023, 960) : loaded_slot());
		end
		settle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both loaded blocks with extreme corners, repeated positions and extreme ids.
		load(0, 0, -8388608, 8388607);
		load(1, 65535, 8388607, -8388608);
		for (int s = 2; s < 64; s++)
			load(s, $urandom, cluster_coord(), cluster_coord());
		load(10, 100, 256, 256);
		load(11, 101, 256, 256);
		load(12, 102, 256, 256);
		load(13, 103, -256, 256);
		load(960, 65535, -8388608, -8388608);
		load(961, 0, 8388607, 8388607);
		for (int s = 962; s < 1024; s++)
			load(s, $urandom, cluster_coord(), cluster_coord());
		settle();

		// Directed: reset registers, active count zero, so the first query finds nothing, then active count 64.
		query(5);
		settle();
		write_reg(rlkne_pkg::REG_ACTIVE_NODES, 64);
		query(0);
		query(10);
		query(5);
		settle();
		// Zero radius keeps only coincident nodes, in slot order on the tie.
		write_reg(rlkne_pkg::REG_CONNECT_RADIUS, 0);
		query(10);
		settle();
		// Widest radius and limits of zero, sixteen and beyond sixteen.
		write_reg(rlkne_pkg::REG_CONNECT_RADIUS, 16777215);
		write_reg(rlkne_pkg::REG_NEIGHBOR_LIMIT, 0);
		query(2);
		settle();
		write_reg(rlkne_pkg::REG_NEIGHBOR_LIMIT, 16);
		query(0);
		query(9);
		settle();
		write_reg(rlkne_pkg::REG_NEIGHBOR_LIMIT, 31);
		query(9);
		query(63);
		query(960);
		settle();
		// Active count at and beyond the store size, source outside the active range.
		write_reg(rlkne_pkg::REG_ACTIVE_NODES, 1024);
		query(960);
		query(1023);
		settle();
		write_reg(rlkne_pkg::REG_ACTIVE_NODES, 2047);
		write_reg(rlkne_pkg::REG_CONNECT_RADIUS, 25600);
		query(990);
		settle();
		write_reg(rlkne_pkg::REG_ACTIVE_NODES, 20);
		query(30);
		query(1000);
		settle();

		// Random phases: receiver idles often, then sender idles often, then neither after a long receiver hold.
		send_idle = 33;
		recv_idle = 78;
		repeat (3) random_block(36);
		send_idle = 78;
		recv_idle = 33;
		repeat (3) random_block(36);
		send_idle = 0;
		recv_idle = 0;
		hold_left = 400;
		repeat (3) random_block(36);

		settle();
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
